FILE: rtl/ahs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ahs_pkg;

    localparam int unsigned WORD_W       = 64;
    localparam int unsigned COUNT_W      = 4;
    localparam int unsigned STATE_WORDS  = 5;
    localparam int unsigned FINAL_ROUNDS = 12;
    localparam int unsigned BLOCK_ROUNDS = 8;
    localparam int unsigned DIGEST_WORDS = 4;
    localparam int unsigned TOTAL_ROUNDS = 12;
    localparam int unsigned ROUND_W      = 4;
    localparam int unsigned DWORD_W      = 2;

    // round index where a run of the given length starts, last index is TOTAL_ROUNDS - 1
    localparam logic [ROUND_W-1:0] BLOCK_START = ROUND_W'(TOTAL_ROUNDS - BLOCK_ROUNDS);
    localparam logic [ROUND_W-1:0] FINAL_START = ROUND_W'(TOTAL_ROUNDS - FINAL_ROUNDS);
    localparam logic [ROUND_W-1:0] LAST_ROUND  = ROUND_W'(TOTAL_ROUNDS - 1);
    localparam logic [DWORD_W-1:0] LAST_DWORD  = DWORD_W'(DIGEST_WORDS - 1);

    localparam logic [WORD_W-1:0] PAD_WORD = 64'h8000_0000_0000_0000;

    typedef logic [WORD_W-1:0] word_t;
    typedef word_t [STATE_WORDS-1:0] sponge_t;

    localparam sponge_t INIT_STATE = '{
        64'ha13c42a223be8d87,
        64'hd6f6a54d7f52377d,
        64'h2ec8e3296c76384c,
        64'h738ec38ac0adffa7,
        64'h01470194fc6528a6
    };

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROUND,
        ST_OUT
    } seq_state_t;

    typedef enum logic [1:0] {
        PH_ABSORB,
        PH_PAD,
        PH_SQUEEZE
    } phase_t;

    function automatic word_t rotr(input word_t v, input int unsigned n);
        rotr = (v >> n) | (v << (WORD_W - n));
    endfunction

    // one round of the permutation, constant taken from the round index
    function automatic sponge_t perm_round(input sponge_t s, input logic [ROUND_W-1:0] idx);
        word_t   x0;
        word_t   x1;
        word_t   x2;
        word_t   x3;
        word_t   x4;
        word_t   t0;
        word_t   t1;
        word_t   t2;
        word_t   t3;
        word_t   t4;
        sponge_t r;
        x0 = s[0];
        x1 = s[1];
        x2 = s[2] ^ {56'd0, ~idx, idx};
        x3 = s[3];
        x4 = s[4];
        x0 = x0 ^ x4;
        x4 = x4 ^ x3;
        x2 = x2 ^ x1;
        t0 = ~x0 & x1;
        t1 = ~x1 & x2;
        t2 = ~x2 & x3;
        t3 = ~x3 & x4;
        t4 = ~x4 & x0;
        x0 = x0 ^ t1;
        x1 = x1 ^ t2;
        x2 = x2 ^ t3;
        x3 = x3 ^ t4;
        x4 = x4 ^ t0;
        x1 = x1 ^ x0;
        x0 = x0 ^ x4;
        x3 = x3 ^ x2;
        x2 = ~x2;
        r[0] = x0 ^ rotr(x0, 19) ^ rotr(x0, 28);
        r[1] = x1 ^ rotr(x1, 61) ^ rotr(x1, 39);
        r[2] = x2 ^ rotr(x2, 1) ^ rotr(x2, 6);
        r[3] = x3 ^ rotr(x3, 10) ^ rotr(x3, 17);
        r[4] = x4 ^ rotr(x4, 7) ^ rotr(x4, 41);
        perm_round = r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/ahs_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface ahs_msg_if;
    import ahs_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [WORD_W-1:0]    block_data;
    logic [COUNT_W-1:0]   byte_count;
    logic                 is_last;

    modport source (output valid, output block_data, output byte_count, output is_last,
                     input ready);
    modport sink   (input valid, input block_data, input byte_count, input is_last,
                     output ready);
endinterface

interface ahs_dig_if;
    import ahs_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [WORD_W-1:0]    digest_word;
    logic                 last_word;

    modport source (output valid, output digest_word, output last_word, input ready);
    modport sink   (input valid, input digest_word, input last_word, output ready);
endinterface

`default_nettype wire

FILE: rtl/ascon_hasha_sponge_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Ascon-HashA sponge, 64-bit rate. One message block enters per msg transaction; a
// single round unit runs one permutation round per cycle and msg is not ready while it
// works. A block that is not last runs BLOCK_ROUNDS rounds, a short last block is padded
// and runs FINAL_ROUNDS, and a full last block runs BLOCK_ROUNDS and then a separate
// padding block with FINAL_ROUNDS. The four digest words follow on dig, each held in the
// state register until taken, with BLOCK_ROUNDS rounds between words. After the fourth
// word is taken the sponge returns to the initial state and msg is ready again.
module ascon_hasha_sponge_unit
    import ahs_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    ahs_msg_if.sink       msg,
    ahs_dig_if.source     dig
);

    seq_state_t          state_reg;
    seq_state_t          state_next;
    phase_t              phase_reg;
    phase_t              phase_next;
    logic [ROUND_W-1:0]  round_reg;
    logic [ROUND_W-1:0]  round_next;
    logic [DWORD_W-1:0]  dword_reg;
    logic [DWORD_W-1:0]  dword_next;
    sponge_t             sponge_reg;
    sponge_t             sponge_next;

    logic                msg_take;
    logic                dig_take;
    logic                full_count;
    logic [5:0]          byte_shift;
    word_t               short_pad;
    sponge_t             round_out;

    assign msg_take   = msg.valid && msg.ready;
    assign dig_take   = dig.valid && dig.ready;
    assign full_count = msg.byte_count[COUNT_W-1];
    assign byte_shift = {msg.byte_count[2:0], 3'b000};
    // keep the leading bytes, put the pad byte right after them
    assign short_pad  = (msg.block_data & ~({WORD_W{1'b1}} >> byte_shift))
                      | (PAD_WORD >> byte_shift);
    assign round_out  = perm_round(sponge_reg, round_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (msg_take)
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                if (round_reg == LAST_ROUND)
                begin
                    case (phase_reg)
                        PH_ABSORB:  state_next = ST_IDLE;
                        PH_PAD:     state_next = ST_ROUND;
                        PH_SQUEEZE: state_next = ST_OUT;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_OUT:
            begin
                if (dig_take)
                begin
                    state_next = (dword_reg == LAST_DWORD) ? ST_IDLE : ST_ROUND;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        msg.ready       = (state_reg == ST_IDLE);
        dig.valid       = (state_reg == ST_OUT);
        dig.digest_word = sponge_reg[0];
        dig.last_word   = (dword_reg == LAST_DWORD);
    end

    // datapath and counters
    always_comb
    begin
        sponge_next = sponge_reg;
        phase_next  = phase_reg;
        round_next  = round_reg;
        dword_next  = dword_reg;
        case (state_reg)
            ST_IDLE:
            begin
                dword_next = '0;
                if (msg_take)
                begin
                    if (!msg.is_last)
                    begin
                        sponge_next[0] = sponge_reg[0] ^ msg.block_data;
                        phase_next     = PH_ABSORB;
                        round_next     = BLOCK_START;
                    end
                    else if (full_count)
                    begin
                        sponge_next[0] = sponge_reg[0] ^ msg.block_data;
                        phase_next     = PH_PAD;
                        round_next     = BLOCK_START;
                    end
                    else
                    begin
                        sponge_next[0] = sponge_reg[0] ^ short_pad;
                        phase_next     = PH_SQUEEZE;
                        round_next     = FINAL_START;
                    end
                end
            end
            ST_ROUND:
            begin
                sponge_next = round_out;
                round_next  = round_reg + 1'b1;
                if ((round_reg == LAST_ROUND) && (phase_reg == PH_PAD))
                begin
                    // separate padding block after a full last block
                    sponge_next[0] = round_out[0] ^ PAD_WORD;
                    phase_next     = PH_SQUEEZE;
                    round_next     = FINAL_START;
                end
            end
            ST_OUT:
            begin
                if (dig_take)
                begin
                    if (dword_reg == LAST_DWORD)
                    begin
                        sponge_next = INIT_STATE;
                    end
                    else
                    begin
                        dword_next = dword_reg + 1'b1;
                        round_next = BLOCK_START;
                    end
                end
            end
            default:
            begin
                sponge_next = INIT_STATE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            phase_reg  <= PH_ABSORB;
            round_reg  <= '0;
            dword_reg  <= '0;
            sponge_reg <= INIT_STATE;
        end
        else
        begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            round_reg  <= round_next;
            dword_reg  <= dword_next;
            sponge_reg <= sponge_next;
        end
    end

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import ahs_pkg::*;

    typedef enum int unsigned {
        RX_OPEN,
        RX_COIN,
        RX_MASK
    } rx_mode_t;

    logic clk = 1'b0;
    logic rst_n;

    ahs_msg_if msg_bus ();
    ahs_dig_if dig_bus ();

    ascon_hasha_sponge_unit uut (
        .clk   (clk),
        .rst_n (rst_n),
        .msg   (msg_bus),
        .dig   (dig_bus)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // predicted sponge and the digest words still owed by the block
    sponge_t     hash_state;
    word_t       digest_q[$];
    bit          final_q[$];

    int unsigned err_count;
    int unsigned msg_count;
    int unsigned block_count;
    int unsigned words_checked;

    // sender burst shaping
    bit          gaps_on;
    int unsigned burst_left;

    // long receiver hold, requested by ticket so only the receiver owns its counter
    int unsigned hold_ticket;
    int unsigned hold_len;

    function automatic word_t rot_right(word_t v, int unsigned n);
        return (v >> n) | (v << (WORD_W - n));
    endfunction

    // last n rounds of the twelve-round permutation
    function automatic void ascon_rounds(int unsigned n);
        word_t a0, a1, a2, a3, a4;
        word_t c0, c1, c2, c3, c4;
        for (int unsigned r = TOTAL_ROUNDS - n; r < TOTAL_ROUNDS; r++)
        begin
            a0 = hash_state[0];
            a1 = hash_state[1];
            a2 = hash_state[2] ^ word_t'(((15 - r) << 4) | r);
            a3 = hash_state[3];
            a4 = hash_state[4];
            a0 ^= a4;
            a4 ^= a3;
            a2 ^= a1;
            c0 = ~a0 & a1;
            c1 = ~a1 & a2;
            c2 = ~a2 & a3;
            c3 = ~a3 & a4;
            c4 = ~a4 & a0;
            a0 ^= c1;
            a1 ^= c2;
            a2 ^= c3;
            a3 ^= c4;
            a4 ^= c0;
            a1 ^= a0;
            a0 ^= a4;
            a3 ^= a2;
            a2 = ~a2;
            hash_state[0] = a0 ^ rot_right(a0, 19) ^ rot_right(a0, 28);
            hash_state[1] = a1 ^ rot_right(a1, 61) ^ rot_right(a1, 39);
            hash_state[2] = a2 ^ rot_right(a2, 1) ^ rot_right(a2, 6);
            hash_state[3] = a3 ^ rot_right(a3, 10) ^ rot_right(a3, 17);
            hash_state[4] = a4 ^ rot_right(a4, 7) ^ rot_right(a4, 41);
        end
    endfunction

    // absorb one accepted block; a last block queues the four digest words
    function automatic void fold_block(word_t data, logic [COUNT_W-1:0] cnt, logic last);
        word_t       pad_w;
        word_t       keep;
        int unsigned nb;
        nb = 32'(cnt);
        block_count++;
        if (!last)
        begin
            hash_state[0] ^= data;
            ascon_rounds(BLOCK_ROUNDS);
            return;
        end
        if (nb >= 8)
        begin
            // full block goes in whole, padding follows as a block of its own
            hash_state[0] ^= data;
            ascon_rounds(BLOCK_ROUNDS);
            pad_w = PAD_WORD;
        end
        else
        begin
            keep  = (nb == 0) ? '0 : (~word_t'(0) << (64 - 8 * nb));
            pad_w = (data & keep) | (PAD_WORD >> (8 * nb));
        end
        hash_state[0] ^= pad_w;
        ascon_rounds(FINAL_ROUNDS);
        for (int unsigned k = 0; k < DIGEST_WORDS; k++)
        begin
            digest_q.push_back(hash_state[0]);
            final_q.push_back(k == DIGEST_WORDS - 1);
            if (k != DIGEST_WORDS - 1)
                ascon_rounds(BLOCK_ROUNDS);
        end
        hash_state = INIT_STATE;
        msg_count++;
    endfunction

    task automatic report_mismatch(string what, word_t got, word_t want);
        $display("tb_top: mismatch on %s: got %h, want %h", what, got, want);
        err_count++;
    endtask

    // one msg transaction; valid stays up, apart from random gaps while gaps_on is set, so back-to-back calls stream
    task automatic send_block(word_t data, logic [COUNT_W-1:0] cnt, logic last);
        msg_bus.valid      <= 1'b1;
        msg_bus.block_data <= data;
        msg_bus.byte_count <= cnt;
        msg_bus.is_last    <= last;
        do
            @(posedge clk);
        while (msg_bus.ready !== 1'b1);
        fold_block(data, cnt, last);
        if (gaps_on)
        begin
            if (burst_left > 0)
                burst_left--;
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 10);
                msg_bus.valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
    endtask

    task automatic wait_drained();
        msg_bus.valid <= 1'b0;
        while (digest_q.size() != 0)
            @(posedge clk);
    endtask

    function automatic word_t rand_word();
        return {$urandom, $urandom};
    endfunction

    // short last blocks of every length, bytes past the count must vanish
    task automatic test_last_counts();
        for (int unsigned c = 0; c < 8; c++)
            send_block((c % 2 == 0) ? ~word_t'(0) : 64'h0123_4567_89ab_cdef,
                       COUNT_W'(c), 1'b1);
        send_block('0, COUNT_W'(0), 1'b1);
        wait_drained();
    endtask

    // full last block takes an extra padding block, counts above eight act as eight
    task automatic test_full_last();
        send_block(~word_t'(0), COUNT_W'(8), 1'b1);
        send_block('0, COUNT_W'(8), 1'b1);
        send_block(64'h5a5a_5a5a_a5a5_a5a5, COUNT_W'(15), 1'b1);
        send_block(64'hfedc_ba98_7654_3210, COUNT_W'(9), 1'b1);
        wait_drained();
    endtask

    // middle blocks absorb all eight bytes whatever the count says
    task automatic test_multi_block();
        send_block('0, COUNT_W'(8), 1'b0);
        send_block(~word_t'(0), COUNT_W'(0), 1'b0);
        send_block(rand_word(), COUNT_W'(5), 1'b0);
        send_block(rand_word(), COUNT_W'(3), 1'b1);
        wait_drained();
    endtask

    task automatic send_message(int unsigned n_mid);
        logic [COUNT_W-1:0] cnt;
        for (int unsigned i = 0; i < n_mid; i++)
        begin
            cnt = ($urandom_range(0, 4) == 0) ? COUNT_W'($urandom_range(0, 15)) : COUNT_W'(8);
            send_block(rand_word(), cnt, 1'b0);
        end
        cnt = ($urandom_range(0, 5) == 0) ? COUNT_W'($urandom_range(9, 15))
                                          : COUNT_W'($urandom_range(0, 8));
        send_block(rand_word(), cnt, 1'b1);
    endtask

    // digest port held off while messages keep coming, so msg must stall
    task automatic test_backpressure();
        hold_len = 300;
        hold_ticket++;
        gaps_on = 1'b0;
        send_message(1);
        send_message(2);
        send_message(0);
        gaps_on = 1'b1;
        wait_drained();
    endtask

    task automatic test_random_messages(int unsigned n_blocks);
        int unsigned start;
        start = block_count;
        while (block_count - start < n_blocks)
        begin
            gaps_on = ($urandom_range(0, 3) != 0);
            send_message($urandom_range(0, 5));
            if ($urandom_range(0, 15) == 0)
                wait_drained();
        end
        gaps_on = 1'b1;
        wait_drained();
    endtask

    initial
    begin
        rst_n              = 1'b0;
        msg_bus.valid      = 1'b0;
        msg_bus.block_data = '0;
        msg_bus.byte_count = '0;
        msg_bus.is_last    = 1'b0;
        hash_state         = INIT_STATE;
        err_count          = 0;
        msg_count          = 0;
        block_count        = 0;
        words_checked      = 0;
        gaps_on            = 1'b1;
        burst_left         = 3;
        hold_ticket        = 0;
        hold_len           = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_last_counts();
        test_full_last();
        test_multi_block();
        test_backpressure();
        test_random_messages(125);

        wait_drained();
        repeat (60) @(posedge clk);
        $display("tb_top: %0d messages in %0d blocks hashed, %0d digest words compared",
                 msg_count, block_count, words_checked);
        $display("tb_top: covered all last-block counts, full and oversize counts, stalls");
        if (err_count == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

    // receiver: random stall patterns, plus long holds on request
    initial
    begin
        int unsigned hold_seen;
        int unsigned hold_left;
        int unsigned mode_left;
        int unsigned mask_pos;
        rx_mode_t    rx_mode;
        logic [15:0] stall_mask;
        hold_seen  = 0;
        hold_left  = 0;
        mode_left  = 0;
        mask_pos   = 0;
        rx_mode    = RX_OPEN;
        stall_mask = '1;
        dig_bus.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_seen != hold_ticket)
            begin
                hold_seen = hold_ticket;
                hold_left = hold_len;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                dig_bus.ready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    rx_mode       = rx_mode_t'($urandom_range(0, 2));
                    mode_left     = $urandom_range(20, 80);
                    stall_mask    = 16'($urandom);
                    stall_mask[0] = 1'b1;
                end
                mode_left--;
                case (rx_mode)
                    RX_OPEN: dig_bus.ready <= 1'b1;
                    RX_COIN: dig_bus.ready <= 1'($urandom_range(0, 1));
                    default:
                    begin
                        dig_bus.ready <= stall_mask[mask_pos[3:0]];
                        mask_pos++;
                    end
                endcase
            end
        end
    end

    // digest checker
    always @(posedge clk)
    begin
        if (rst_n && dig_bus.valid === 1'b1 && dig_bus.ready === 1'b1)
        begin
            if (digest_q.size() == 0)
                report_mismatch("unexpected digest word", dig_bus.digest_word, '0);
            else
            begin
                if (dig_bus.digest_word !== digest_q[0])
                    report_mismatch("digest_word", dig_bus.digest_word, digest_q[0]);
                if (dig_bus.last_word !== final_q[0])
                    report_mismatch("last_word", word_t'(dig_bus.last_word),
                                    word_t'(final_q[0]));
                void'(digest_q.pop_front());
                void'(final_q.pop_front());
                words_checked++;
            end
        end
    end

    initial
    begin
        #400000;
        $display("tb_top: timeout with %0d digest words outstanding", digest_q.size());
        $display("tb_top: done, errors");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/ahs_pkg.sv
rtl/ahs_if.sv
rtl/ascon_hasha_sponge_unit.sv
bench/tb_top.sv
